// File: sv/cfsc_pkg.sv
// Shared types, character codes and range checks for the cron field syntax checker.
package cfsc_pkg;

   localparam int CHAR_WIDTH  = 8;
   localparam int KIND_WIDTH  = 3;
   localparam int VALUE_WIDTH = 7;
   localparam int COUNT_WIDTH = 2;
   localparam int FLAG_WIDTH  = 6;
   localparam int DIGIT_WIDTH = 4;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_STAR  = 8'h2a;
   localparam logic [CHAR_WIDTH-1:0] CHAR_DASH  = 8'h2d;
   localparam logic [CHAR_WIDTH-1:0] CHAR_SLASH = 8'h2f;
   localparam logic [CHAR_WIDTH-1:0] CHAR_COMMA = 8'h2c;

   localparam logic [KIND_WIDTH-1:0] KIND_MINUTE  = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_HOUR    = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_DAY     = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_MONTH   = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_WEEKDAY = 3'd4;

   localparam logic [FLAG_WIDTH-1:0] MASK_STAR  = 6'b000001;
   localparam logic [FLAG_WIDTH-1:0] MASK_NUM   = 6'b000010;
   localparam logic [FLAG_WIDTH-1:0] MASK_SLASH = 6'b000100;
   localparam logic [FLAG_WIDTH-1:0] MASK_DASH  = 6'b001000;
   localparam logic [FLAG_WIDTH-1:0] MASK_COMMA = 6'b010000;
   localparam logic [FLAG_WIDTH-1:0] MASK_RANGE = 6'b100000;

   typedef struct packed {
      logic [FLAG_WIDTH-1:0]  token_flags;
      logic [VALUE_WIDTH-1:0] current_value;
      logic [VALUE_WIDTH-1:0] previous_value;
      logic [COUNT_WIDTH-1:0] digit_count;
      logic                   error_seen;
      logic [KIND_WIDTH-1:0]  latched_kind;
      logic                   at_field_start;
   } cfsc_state_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] char_code;
      logic [KIND_WIDTH-1:0] field_kind;
      logic                  end_of_field;
   } cfsc_item_type;

   function automatic logic in_range(logic [KIND_WIDTH-1:0] kind,
                                     logic [VALUE_WIDTH-1:0] v);
      logic ok;
      case (kind)
         KIND_MINUTE:  ok = (v <= 7'd59);
         KIND_HOUR:    ok = (v <= 7'd23);
         KIND_DAY:     ok = (v >= 7'd1) && (v <= 7'd31);
         KIND_MONTH:   ok = (v >= 7'd1) && (v <= 7'd12);
         KIND_WEEKDAY: ok = (v <= 7'd6);
         default:      ok = 1'b0;
      endcase
      return ok;
   endfunction

   function automatic cfsc_state_type finish_number(cfsc_state_type s);
      cfsc_state_type r;
      r = s;
      r.digit_count = '0;
      if (((s.token_flags & MASK_DASH) != '0) && (s.previous_value > s.current_value))
         r.error_seen = 1'b1;
      if (!in_range(s.latched_kind, s.current_value))
         r.error_seen = 1'b1;
      r.token_flags    = s.token_flags & ~MASK_DASH;
      r.previous_value = s.current_value;
      return r;
   endfunction

endpackage

// File: sv/cfsc_step.sv
// Per-character next-state and verdict logic of the cron field syntax checker.
module cfsc_step (
   input  cfsc_pkg::cfsc_state_type state_i,
   input  cfsc_pkg::cfsc_item_type  item_i,
   output cfsc_pkg::cfsc_state_type state_o,
   output logic                     field_valid_o
);

   cfsc_pkg::cfsc_state_type s;
   logic [cfsc_pkg::CHAR_WIDTH-1:0]  char_off;
   logic [cfsc_pkg::DIGIT_WIDTH-1:0] digit;
   logic [cfsc_pkg::FLAG_WIDTH-1:0]  f;
   logic                             is_digit;
   logic                             op_bad;

   assign char_off = item_i.char_code - cfsc_pkg::CHAR_ZERO;
   assign digit    = char_off[cfsc_pkg::DIGIT_WIDTH-1:0];
   assign is_digit = (item_i.char_code >= cfsc_pkg::CHAR_ZERO) &&
                     (item_i.char_code <= cfsc_pkg::CHAR_NINE);

   always_comb begin
      s      = state_i;
      f      = '0;
      op_bad = 1'b0;
      if (s.at_field_start) begin
         s.token_flags    = '0;
         s.current_value  = '0;
         s.previous_value = '0;
         s.digit_count    = '0;
         s.error_seen     = 1'b0;
         s.latched_kind   = item_i.field_kind;
         s.at_field_start = 1'b0;
      end
      if (!s.error_seen) begin
         if (is_digit) begin
            if (s.digit_count == 2'd0) begin
               if ((s.token_flags & (cfsc_pkg::MASK_STAR | cfsc_pkg::MASK_NUM)) != '0) begin
                  s.error_seen = 1'b1;
               end else begin
                  s.token_flags   = (s.token_flags | cfsc_pkg::MASK_NUM) &
                                    ~(cfsc_pkg::MASK_SLASH | cfsc_pkg::MASK_COMMA);
                  s.current_value = {3'b000, digit};
                  s.digit_count   = 2'd1;
               end
            end else if (s.digit_count == 2'd1) begin
               if (s.current_value == '0) begin
                  s.error_seen = 1'b1;
               end else begin
                  s.current_value = (s.current_value << 3) + (s.current_value << 1) +
                                    {3'b000, digit};
                  s.digit_count   = 2'd2;
               end
            end else begin
               s.error_seen = 1'b1;
            end
         end else begin
            if (s.digit_count != 2'd0)
               s = cfsc_pkg::finish_number(s);
            if (!s.error_seen) begin
               f = s.token_flags;
               case (item_i.char_code)
                  cfsc_pkg::CHAR_STAR: begin
                     op_bad = (f & (cfsc_pkg::MASK_STAR | cfsc_pkg::MASK_NUM |
                                    cfsc_pkg::MASK_SLASH | cfsc_pkg::MASK_DASH)) != '0;
                     f = (f & ~cfsc_pkg::MASK_COMMA) | cfsc_pkg::MASK_STAR |
                         cfsc_pkg::MASK_RANGE;
                  end
                  cfsc_pkg::CHAR_DASH: begin
                     op_bad = ((f & (cfsc_pkg::MASK_RANGE | cfsc_pkg::MASK_STAR |
                                     cfsc_pkg::MASK_SLASH | cfsc_pkg::MASK_DASH |
                                     cfsc_pkg::MASK_COMMA)) != '0) ||
                              ((f & cfsc_pkg::MASK_NUM) == '0);
                     f = (f & ~cfsc_pkg::MASK_NUM) | cfsc_pkg::MASK_DASH |
                         cfsc_pkg::MASK_RANGE;
                  end
                  cfsc_pkg::CHAR_SLASH: begin
                     op_bad = (f & cfsc_pkg::MASK_RANGE) == '0;
                     f = (f & ~(cfsc_pkg::MASK_STAR | cfsc_pkg::MASK_NUM |
                                cfsc_pkg::MASK_RANGE)) | cfsc_pkg::MASK_SLASH;
                  end
                  cfsc_pkg::CHAR_COMMA: begin
                     op_bad = (f & (cfsc_pkg::MASK_SLASH | cfsc_pkg::MASK_COMMA |
                                    cfsc_pkg::MASK_DASH)) != '0;
                     f = (f & ~(cfsc_pkg::MASK_RANGE | cfsc_pkg::MASK_STAR |
                                cfsc_pkg::MASK_NUM)) | cfsc_pkg::MASK_COMMA;
                     if (!op_bad)
                        s.previous_value = '0;
                  end
                  default: begin
                     op_bad = 1'b1;
                  end
               endcase
               if (op_bad)
                  s.error_seen = 1'b1;
               else
                  s.token_flags = f;
            end
         end
      end
      if (item_i.end_of_field) begin
         if (!s.error_seen && (s.digit_count != 2'd0))
            s = cfsc_pkg::finish_number(s);
         s.at_field_start = 1'b1;
      end
      field_valid_o = !s.error_seen;
      state_o       = s;
   end

endmodule

// File: sv/cron_field_syntax_checker_unit.sv
// Top level of the cron field syntax checker: input register, field state and result register.
//
//   channel  direction  transaction content
//   req_     in         tdata[7:0] char_code, tuser[2:0] field_kind, tlast end_of_field
//   rsp_     out        tdata[0] field_valid, one per field on its last character
//
// One character per cycle, but a field's last character waits while a verdict stalls on rsp_.
// A character is checked in the cycle after it is taken; the verdict is registered for rsp_.
// The per-character loop is the field state register fed back through the step logic.
// Reset clears the valid flags and the field state; the next character starts a field.
// While a verdict stalls on rsp_, characters without tlast keep being checked.
module cron_field_syntax_checker_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic [2:0] req_tuser,   // [2:0] field_kind
   input  logic       req_tlast,   // end_of_field
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] field_valid, [7:1] zero
);

   logic                     in_valid_ff;
   cfsc_pkg::cfsc_item_type  in_item_ff;
   cfsc_pkg::cfsc_item_type  in_item_in;
   cfsc_pkg::cfsc_state_type state_ff;
   cfsc_pkg::cfsc_state_type state_in;
   logic                     out_valid_ff;
   logic                     out_field_valid_ff;
   logic                     step_field_valid;
   logic                     advance;
   logic                     out_free;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!in_item_ff.end_of_field || out_free);
   assign req_tready = !in_valid_ff || advance;

   assign in_item_in.char_code    = req_tdata;
   assign in_item_in.field_kind   = req_tuser;
   assign in_item_in.end_of_field = req_tlast;

   cfsc_step u_step (
      .state_i       (state_ff),
      .item_i        (in_item_ff),
      .state_o       (state_in),
      .field_valid_o (step_field_valid)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid)
         in_item_ff <= in_item_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{at_field_start: 1'b1, default: '0};
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && in_item_ff.end_of_field) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_item_ff.end_of_field)
         out_field_valid_ff <= step_field_valid;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0000000, out_field_valid_ff};

endmodule

// File: sv/cfsc_checker.sv
// Port-level checks of the cron field syntax checker, bound to the top level.
module cfsc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic [2:0] req_tuser,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   logic req_seen;
   assign req_seen = req_tvalid || (req_tdata != '0) || (req_tuser != '0);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tlast, 2))
      else $error("response without a last character");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:1] == 7'b0000000) || req_seen)
      else $error("response padding not zero");

endmodule

bind cron_field_syntax_checker_unit cfsc_checker u_cfsc_checker (.*);
